// File: sv/assert_macros.svh
// assertion macros shared by the hash block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while in reset
`define SSH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ssh assertion failed");

// clocked implication, disabled while in reset
`define SSH_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("ssh implication failed");

`endif

// File: sv/ssh_pkg.sv
// package for the seeded string hash: constants, state type, control structs
`timescale 1ns / 1ps
package ssh_pkg;

  localparam int unsigned HashW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned DivCntW = $clog2(HashW);

  localparam logic [HalfW-1:0] FNV_PRIME = 32'd16777619;
  localparam logic [HashW-1:0] DJB_START = 64'd5381;
  // multiply by 33 is shift by 5 plus one
  localparam int unsigned DJB_SHIFT = 5;

  localparam logic [CfgAddrW-1:0] CFG_HASH_MODE = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_HASH_SEED = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_MOD_EN    = 2'd2;
  localparam logic [CfgAddrW-1:0] CFG_MODULUS   = 2'd3;

  localparam logic [DivCntW-1:0] DIV_CNT_MAX = DivCntW'(HashW - 1);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FIN,
    ST_DIV,
    ST_DONE
  } ssh_state_e;

  typedef struct packed {
    logic accept;
    logic load_div;
    logic load_out_fin;
    logic div_step;
    logic load_out_div;
  } ssh_cmd_t;

  typedef struct packed {
    logic div_needed;
  } ssh_status_t;

endpackage

// File: sv/ssh_ctrl.sv
// controller state machine for the seeded string hash
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ssh_ctrl
  import ssh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        last_item_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  ssh_status_t status_i,
  output ssh_cmd_t    cmd_o
);

  ssh_state_e         state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (in_valid_i && last_item_i) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (status_i.div_needed) state_d = ST_DIV;
        else if (out_free) state_d = ST_RUN;
      end
      ST_DIV: begin
        if (cnt_q == DIV_CNT_MAX) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_RUN;
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_RUN: begin
        in_stall_o = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_FIN: begin
        cmd_o.load_div = status_i.div_needed;
        cmd_o.load_out_fin = !status_i.div_needed && out_free;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_DONE: begin
        cmd_o.load_out_div = out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    cnt_d = (state_q == ST_DIV) ? cnt_q + 1'b1 : '0;
    out_valid_d = out_valid_q;
    if (cmd_o.load_out_fin || cmd_o.load_out_div) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SSH_ASSERT_IMPL(a_out_src, $rose(out_valid_q),
                   $past(state_q) == ST_FIN || $past(state_q) == ST_DONE)
  `SSH_ASSERT(a_div_end, (state_q == ST_DIV && cnt_q == DIV_CNT_MAX) |=> state_q == ST_DONE)
  `SSH_ASSERT(a_div_stay, (state_q == ST_DIV && cnt_q != DIV_CNT_MAX) |=> state_q == ST_DIV)
  `SSH_ASSERT(a_out_hold, (out_valid_q && out_stall_i) |=> out_valid_q)

endmodule

// File: sv/ssh_datapath.sv
// datapath: config registers, running hash, finishing add and restoring divider
`timescale 1ns / 1ps
module ssh_datapath
  import ssh_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [HashW-1:0]    cfg_data_i,
  input  logic [ByteW-1:0]    data_byte_i,
  input  logic                byte_present_i,
  input  logic                last_item_i,
  input  ssh_cmd_t            cmd_i,
  output ssh_status_t         status_o,
  output logic [HashW-1:0]    hash_value_o,
  output logic                modulus_error_o
);

  logic             mode_q, mod_en_q;
  logic [HalfW-1:0] seed_q;
  logic [HashW-1:0] modulus_q;

  logic [HashW-1:0] rh_q, rh_d;
  logic             start_q;
  logic [HashW-1:0] start_h, djb, absorbed, final_h;
  logic [HalfW-1:0] fnv_full;
  logic [HashW-1:0] rem_q, dvd_q;
  logic [HashW:0]   shifted, diff;
  logic [HashW-1:0] hash_q;
  logic             err_q;
  logic             mod_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      seed_q <= '0;
      mod_en_q <= 1'b0;
      modulus_q <= HashW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_HASH_MODE: mode_q <= cfg_data_i[0];
        CFG_HASH_SEED: seed_q <= cfg_data_i[HalfW-1:0];
        CFG_MOD_EN:    mod_en_q <= cfg_data_i[0];
        CFG_MODULUS:   modulus_q <= cfg_data_i;
        default:       mode_q <= mode_q;
      endcase
    end
  end

  // per byte update
  always_comb begin
    if (start_q) start_h = mode_q ? DJB_START : {{HalfW{1'b0}}, seed_q};
    else start_h = rh_q;
    fnv_full = start_h[HalfW-1:0] * FNV_PRIME;
    djb = ((start_h << DJB_SHIFT) + start_h) ^ {{(HashW-ByteW){data_byte_i[ByteW-1]}}, data_byte_i};
    if (mode_q) absorbed = djb;
    else absorbed = {{HalfW{1'b0}}, fnv_full[HalfW-1:0] ^ {{(HalfW-ByteW){1'b0}}, data_byte_i}};
    rh_d = byte_present_i ? absorbed : start_h;
    if (!mode_q) rh_d = {{HalfW{1'b0}}, rh_d[HalfW-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rh_q <= '0;
      start_q <= 1'b1;
    end else if (cmd_i.accept) begin
      rh_q <= rh_d;
      start_q <= last_item_i;
    end
  end

  // end of message
  assign final_h = mode_q ? rh_q + {{HalfW{1'b0}}, seed_q} : {{HalfW{1'b0}}, rh_q[HalfW-1:0]};
  assign mod_zero = (modulus_q == '0);
  assign status_o.div_needed = mod_en_q && !mod_zero;

  // one remainder bit per cycle
  assign shifted = {rem_q, dvd_q[HashW-1]};
  assign diff = shifted - {1'b0, modulus_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_div) begin
      dvd_q <= final_h;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      rem_q <= diff[HashW] ? shifted[HashW-1:0] : diff[HashW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out_fin) begin
      hash_q <= (mod_en_q && mod_zero) ? '0 : final_h;
      err_q <= mod_en_q && mod_zero;
    end else if (cmd_i.load_out_div) begin
      hash_q <= rem_q;
      err_q <= 1'b0;
    end
  end

  assign hash_value_o = hash_q;
  assign modulus_error_o = err_q;

endmodule

// File: sv/seeded_string_hash_mod.sv
// top level of the seeded string hash with optional modulo reduction
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------------
//   in       | in_valid_i / in_stall_o   | data_byte_i, byte_present_i, last_item_i
//   out      | out_valid_o / out_stall_i | hash_value_o, modulus_error_o
//   cfg      | cfg_we_i                  | cfg_addr_i, cfg_data_i
//
// one byte item is taken per cycle while in_stall_o is low; the running hash register is updated in place
// the last item is followed by a finishing state for the seed add and the output or divider load
// with modulo on and a nonzero modulus, the bit-serial divider runs and a done state loads the output
// input is stalled from the last item until its result sits in the output register
// reset needs no clearing pass; output stall holds the finished result and also holds back the next result
`timescale 1ns / 1ps
module seeded_string_hash_mod
  import ssh_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [HashW-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ByteW-1:0]    data_byte_i,
  input  logic                byte_present_i,
  input  logic                last_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [HashW-1:0]    hash_value_o,
  output logic                modulus_error_o
);

  ssh_cmd_t    cmd;
  ssh_status_t status;

  ssh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_item_i (last_item_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ssh_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .data_byte_i     (data_byte_i),
    .byte_present_i  (byte_present_i),
    .last_item_i     (last_item_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .hash_value_o    (hash_value_o),
    .modulus_error_o (modulus_error_o)
  );

endmodule
